>>> hw/rtl/fpts_pkg.sv
// Package for the fixed-priority tick scheduler: widths, register indexes,
// reset values and the per-task status struct shared by all modules.
// No dependencies.
`default_nettype none

package fpts_pkg;

	localparam int unsigned MAX_TASKS  = 3;
	localparam int unsigned PRIO_W     = 7;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned IDX_W      = 2;
	localparam int unsigned LED_W      = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [PRIO_W-1:0] PRIO_LIMIT = 7'd99;

	localparam logic [CFG_IDX_W-1:0] REG_PRIO0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd3;

	localparam logic [PRIO_W-1:0]   PRIO_RESET   [MAX_TASKS] = '{7'd2, 7'd3, 7'd4};
	localparam logic [PERIOD_W-1:0] PERIOD_RESET [MAX_TASKS] = '{16'd8, 16'd12, 16'd16};

	typedef struct packed {
		logic              eligible;
		logic [PRIO_W-1:0] prio;
		logic [PRIO_W-1:0] budget;
	} lane_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
	} sel_t;

endpackage

`default_nettype wire

>>> hw/rtl/fpts_task_lane.sv
// One task of the scheduler: priority and period registers, budget and phase.
// Depends on fpts_pkg.
`default_nettype none

module fpts_task_lane #(
	parameter int unsigned TASK_ID = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            prio_we,
	input  wire logic                            period_we,
	input  wire logic [fpts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            advance,
	input  wire logic                            win,
	output fpts_pkg::lane_t                      status
);
	import fpts_pkg::*;

	logic [PRIO_W-1:0]   prio_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PRIO_W-1:0]   budget_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [PRIO_W-1:0]   eff_budget;
	logic [PERIOD_W:0]   phase_inc;
	logic [PERIOD_W-1:0] phase_next;

	assign eff_budget = (phase_q == '0) ? prio_q : budget_q;
	assign phase_inc  = {1'b0, phase_q} + {{PERIOD_W{1'b0}}, 1'b1};
	assign phase_next = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[PERIOD_W-1:0];

	assign status.eligible = (eff_budget != '0) && (prio_q < PRIO_LIMIT);
	assign status.prio     = prio_q;
	assign status.budget   = eff_budget;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q   <= PRIO_RESET[TASK_ID];
			period_q <= PERIOD_RESET[TASK_ID];
			budget_q <= '0;
			phase_q  <= '0;
		end else begin
			if (prio_we) begin
				prio_q <= cfg_data[PRIO_W-1:0];
			end
			if (period_we) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
			if (advance) begin
				budget_q <= win ? (eff_budget - {{(PRIO_W-1){1'b0}}, 1'b1}) : eff_budget;
				phase_q  <= phase_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fpts_select.sv
// Picks the eligible task with the lowest priority value, lower index on ties.
// Depends on fpts_pkg.
`default_nettype none

module fpts_select #(
	parameter int unsigned NUM_TASKS = 3
) (
	input  fpts_pkg::lane_t [NUM_TASKS-1:0] lanes,
	output fpts_pkg::sel_t                  sel
);
	import fpts_pkg::*;

	always_comb begin
		logic [PRIO_W-1:0] best;
		best      = PRIO_LIMIT;
		sel.valid = 1'b0;
		sel.index = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (lanes[i].eligible && (lanes[i].prio < best)) begin
				best      = lanes[i].prio;
				sel.valid = 1'b1;
				sel.index = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fixed_priority_tick_scheduler_core.sv
// Fixed-priority tick scheduler, top level. Depends on fpts_pkg,
// fpts_task_lane and fpts_select.
// A tick request is accepted into the input register and then written to the result register.
// Throughput: one request per cycle while in_stall is low; the input register holds
// one more request while a result is stalled. Requests with tick low give no result.
// Reset clears budgets, phases and the input and output valid flags and loads the default registers.
`default_nettype none

module fixed_priority_tick_scheduler_core #(
	parameter int unsigned NUM_TASKS = 3
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fpts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            tick,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 task_valid,
	output logic [fpts_pkg::IDX_W-1:0]           task_index,
	output logic [fpts_pkg::LED_W-1:0]           led_onehot,
	output logic [fpts_pkg::PRIO_W-1:0]          budget_left
);
	import fpts_pkg::*;

	logic                    valid_s1;
	logic                    tick_s1;
	logic                    advance;
	logic                    step;
	lane_t [NUM_TASKS-1:0]   lanes;
	sel_t                    sel;
	logic [PRIO_W-1:0]       budget_new;
	logic                    out_valid_q;
	logic                    task_valid_q;
	logic [IDX_W-1:0]        task_index_q;
	logic [LED_W-1:0]        led_onehot_q;
	logic [PRIO_W-1:0]       budget_left_q;

	assign advance  = valid_s1 && (!tick_s1 || !out_valid_q || !out_stall);
	assign step     = advance && tick_s1;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1 <= tick;
		end
	end

	for (genvar g = 0; g < NUM_TASKS; g++) begin : g_lane
		fpts_task_lane #(
			.TASK_ID(g)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.prio_we   (cfg_we && (cfg_index == CFG_IDX_W'(REG_PRIO0 + g))),
			.period_we (cfg_we && (cfg_index == CFG_IDX_W'(REG_PERIOD0 + g))),
			.cfg_data  (cfg_data),
			.advance   (step),
			.win       (sel.valid && (sel.index == IDX_W'(g))),
			.status    (lanes[g])
		);
	end

	fpts_select #(
		.NUM_TASKS(NUM_TASKS)
	) u_select (
		.lanes (lanes),
		.sel   (sel)
	);

	always_comb begin
		budget_new = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (sel.valid && (sel.index == IDX_W'(i))) begin
				budget_new = lanes[i].budget - {{(PRIO_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			task_valid_q  <= sel.valid;
			task_index_q  <= sel.valid ? sel.index : '0;
			led_onehot_q  <= sel.valid ? (LED_W'(1) << sel.index) : '0;
			budget_left_q <= budget_new;
		end
	end

	assign out_valid   = out_valid_q;
	assign task_valid  = task_valid_q;
	assign task_index  = task_index_q;
	assign led_onehot  = led_onehot_q;
	assign budget_left = budget_left_q;

endmodule

`default_nettype wire
